### rtl/core/dtg_pkg.sv
// Shared types, constants and table functions for the DTMF tone generator.
package dtg_pkg;

    localparam int PHASE_PER_HZ_W  = 22;
    localparam int TONE_SAMPLES_W  = 16;
    localparam int PAUSE_SAMPLES_W = 16;
    localparam int AMPLITUDE_W     = 15;
    localparam int CFG_DATA_W      = 22;
    localparam int CFG_ADDR_W      = 2;
    localparam int KEY_W           = 8;
    localparam int SAMPLE_W        = 16;
    localparam int FREQ_W          = 11;
    localparam int SINE_MAG_W      = 15;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int COUNT_BITS_DEF      = 16;

    localparam logic [PHASE_PER_HZ_W-1:0]  PHASE_PER_HZ_RST  = 22'd536871;
    localparam logic [TONE_SAMPLES_W-1:0]  TONE_SAMPLES_RST  = 16'd800;
    localparam logic [PAUSE_SAMPLES_W-1:0] PAUSE_SAMPLES_RST = 16'd400;
    localparam logic [AMPLITUDE_W-1:0]     AMPLITUDE_RST     = 15'd16384;

    localparam logic [SINE_MAG_W-1:0] SINE_PEAK = 15'h7FFF;

    // row tones
    localparam logic [FREQ_W-1:0] FREQ_ROW0 = 11'd697;
    localparam logic [FREQ_W-1:0] FREQ_ROW1 = 11'd770;
    localparam logic [FREQ_W-1:0] FREQ_ROW2 = 11'd852;
    localparam logic [FREQ_W-1:0] FREQ_ROW3 = 11'd941;
    // column tones
    localparam logic [FREQ_W-1:0] FREQ_COL0 = 11'd1209;
    localparam logic [FREQ_W-1:0] FREQ_COL1 = 11'd1336;
    localparam logic [FREQ_W-1:0] FREQ_COL2 = 11'd1477;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PHASE_PER_HZ  = 2'd0,
        CFG_TONE_SAMPLES  = 2'd1,
        CFG_PAUSE_SAMPLES = 2'd2,
        CFG_AMPLITUDE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PHASE_PER_HZ_W-1:0]  phase_per_hz;
        logic [TONE_SAMPLES_W-1:0]  tone_samples;
        logic [PAUSE_SAMPLES_W-1:0] pause_samples;
        logic [AMPLITUDE_W-1:0]     amplitude;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] low_freq;
        logic [FREQ_W-1:0] high_freq;
    } key_freq_t;

    // Polynomial coefficients of the quarter sine, Q30
    localparam logic [63:0] C1  = 64'd1686629713;
    localparam logic [63:0] C3  = 64'd693598669;
    localparam logic [63:0] C5  = 64'd85569306;
    localparam logic [63:0] C7  = 64'd5026994;
    localparam logic [63:0] C9  = 64'd172272;
    localparam logic [63:0] C11 = 64'd3864;

    // sin(pi/2 * r / 2^qbits) in Q15, evaluated at elaboration for table entries
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned r,
                                                           input int unsigned qbits);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        u  = 64'(r) << (30 - qbits);
        u2 = (u * u) >> 30;
        p  = C11;
        p  = C9 - ((u2 * p) >> 30);
        p  = C7 - ((u2 * p) >> 30);
        p  = C5 - ((u2 * p) >> 30);
        p  = C3 - ((u2 * p) >> 30);
        p  = C1 - ((u2 * p) >> 30);
        s  = (u * p) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[SINE_MAG_W-1:0];
    endfunction

    function automatic key_freq_t key_decode(input logic [KEY_W-1:0] key);
        key_freq_t kf;
        kf.valid     = 1'b1;
        kf.low_freq  = FREQ_ROW0;
        kf.high_freq = FREQ_COL0;
        unique case (key)
            8'h31: begin kf.low_freq = FREQ_ROW0; kf.high_freq = FREQ_COL0; end
            8'h32: begin kf.low_freq = FREQ_ROW0; kf.high_freq = FREQ_COL1; end
            8'h33: begin kf.low_freq = FREQ_ROW0; kf.high_freq = FREQ_COL2; end
            8'h34: begin kf.low_freq = FREQ_ROW1; kf.high_freq = FREQ_COL0; end
            8'h35: begin kf.low_freq = FREQ_ROW1; kf.high_freq = FREQ_COL1; end
            8'h36: begin kf.low_freq = FREQ_ROW1; kf.high_freq = FREQ_COL2; end
            8'h37: begin kf.low_freq = FREQ_ROW2; kf.high_freq = FREQ_COL0; end
            8'h38: begin kf.low_freq = FREQ_ROW2; kf.high_freq = FREQ_COL1; end
            8'h39: begin kf.low_freq = FREQ_ROW2; kf.high_freq = FREQ_COL2; end
            8'h2A: begin kf.low_freq = FREQ_ROW3; kf.high_freq = FREQ_COL0; end
            8'h30: begin kf.low_freq = FREQ_ROW3; kf.high_freq = FREQ_COL1; end
            8'h23: begin kf.low_freq = FREQ_ROW3; kf.high_freq = FREQ_COL2; end
            default: kf.valid = 1'b0;
        endcase
        return kf;
    endfunction

endpackage

### rtl/core/dtg_sine_rom.sv
// Sine lookup: quarter-wave constant table with mirroring and sign for the other quarters.
module dtg_sine_rom
    import dtg_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic [TABLE_BITS-1:0]      idx,
    output logic signed [SAMPLE_W-1:0] value
);

    localparam int QB    = TABLE_BITS - 2;
    localparam int QSIZE = 1 << QB;

    logic [SINE_MAG_W-1:0] qtab [QSIZE];
    logic [1:0]            quad;
    logic [QB-1:0]         r;
    logic [QB-1:0]         ridx;
    logic [SINE_MAG_W-1:0] mag;

    for (genvar i = 0; i < QSIZE; i++)
    begin : g_tab
        assign qtab[i] = quarter_sine(i, QB);
    end

    assign quad = idx[TABLE_BITS-1 -: 2];
    assign r    = idx[QB-1:0];

    // mirror odd quarters; the peak entry lies one past the table
    always_comb
    begin
        ridx = quad[0] ? (QB'(0) - r) : r;
        if (quad[0] && (r == '0))
        begin
            mag = SINE_PEAK;
        end
        else
        begin
            mag = qtab[ridx];
        end
        if (quad[1])
        begin
            value = SAMPLE_W'(0) - SAMPLE_W'(mag);
        end
        else
        begin
            value = SAMPLE_W'(mag);
        end
    end

endmodule

### rtl/core/dtg_cfg_regs.sv
// Configuration register file with reset values.
module dtg_cfg_regs
    import dtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_PHASE_PER_HZ:  cfg_next.phase_per_hz  = cfg_wdata[PHASE_PER_HZ_W-1:0];
                CFG_TONE_SAMPLES:  cfg_next.tone_samples  = cfg_wdata[TONE_SAMPLES_W-1:0];
                CFG_PAUSE_SAMPLES: cfg_next.pause_samples = cfg_wdata[PAUSE_SAMPLES_W-1:0];
                CFG_AMPLITUDE:     cfg_next.amplitude     = cfg_wdata[AMPLITUDE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_per_hz  <= PHASE_PER_HZ_RST;
            cfg_reg.tone_samples  <= TONE_SAMPLES_RST;
            cfg_reg.pause_samples <= PAUSE_SAMPLES_RST;
            cfg_reg.amplitude     <= AMPLITUDE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/dtg_core.sv
// Input register, tone/pause sequencing, dual sine synthesis and result register.
module dtg_core
    import dtg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [KEY_W-1:0]    in_key,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] out_sample,
    output logic                out_tone_on,
    output logic                out_last
);

    localparam int CW = (COUNT_BITS + 1 > TONE_SAMPLES_W + 1) ? COUNT_BITS + 1
                                                              : TONE_SAMPLES_W + 1;
    localparam int EW = (PHASE_BITS > PHASE_PER_HZ_W + FREQ_W) ? PHASE_BITS
                                                               : PHASE_PER_HZ_W + FREQ_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

    // input stage
    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic [KEY_W-1:0]   in_key_reg;

    // tone state
    logic                  busy_reg, busy_next;
    logic                  in_pause_reg, in_pause_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PHASE_BITS-1:0] low_phase_reg, low_phase_next;
    logic [PHASE_BITS-1:0] high_phase_reg, high_phase_next;
    logic [PHASE_BITS-1:0] low_step_reg, low_step_next;
    logic [PHASE_BITS-1:0] high_step_reg, high_step_next;

    // result stage
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_tone_reg, out_tone_next;
    logic                out_last_reg, out_last_next;

    logic out_free;
    logic is_tick;
    logic process;
    logic tick_fire;

    key_freq_t                   kf;
    logic [EW-1:0]               low_prod;
    logic [EW-1:0]               high_prod;
    logic signed [SAMPLE_W-1:0]  low_sin;
    logic signed [SAMPLE_W-1:0]  high_sin;
    logic signed [SAMPLE_W:0]    sum;
    logic [SAMPLE_W:0]           mag;
    logic [31:0]                 scaled;
    logic [SAMPLE_W-1:0]         vmag;
    logic [SAMPLE_W-1:0]         tone_sample;
    logic [CW-1:0]               count_inc;
    logic                        tone_end;
    logic                        pause_end;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_tick   = (in_cmd_reg == CMD_TICK);
    assign process   = in_valid_reg && (!is_tick || out_free);
    assign tick_fire = process && is_tick;
    assign in_ready  = !in_valid_reg || process;

    dtg_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_low_rom
    (
        .idx   (low_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .value (low_sin)
    );

    dtg_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_high_rom
    (
        .idx   (high_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .value (high_sin)
    );

    // sample = sign * trunc(|lo + hi| * amplitude / 2^16)
    always_comb
    begin
        sum         = (SAMPLE_W+1)'(low_sin) + (SAMPLE_W+1)'(high_sin);
        mag         = sum[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - sum) : sum;
        scaled      = 32'(mag) * 32'(cfg.amplitude);
        vmag        = scaled[31:16];
        tone_sample = sum[SAMPLE_W] ? (SAMPLE_W'(0) - vmag) : vmag;
    end

    assign kf        = key_decode(in_key_reg);
    assign low_prod  = EW'(kf.low_freq) * EW'(cfg.phase_per_hz);
    assign high_prod = EW'(kf.high_freq) * EW'(cfg.phase_per_hz);

    assign count_inc = CW'(count_reg) + CW'(1);
    assign tone_end  = (count_inc >= CW'(cfg.tone_samples)) || (count_inc >= COUNT_MAX);
    assign pause_end = (count_inc >= CW'(cfg.pause_samples)) || (count_inc >= COUNT_MAX);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        in_pause_next   = in_pause_reg;
        count_next      = count_reg;
        low_phase_next  = low_phase_reg;
        high_phase_next = high_phase_reg;
        low_step_next   = low_step_reg;
        high_step_next  = high_step_reg;
        out_sample_next = out_sample_reg;
        out_tone_next   = out_tone_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (process && !is_tick)
        begin
            // start a tone; drop keys while busy, invalid keys and empty tones
            if (!busy_reg && (cfg.tone_samples != '0) && kf.valid)
            begin
                low_step_next   = low_prod[PHASE_BITS-1:0];
                high_step_next  = high_prod[PHASE_BITS-1:0];
                low_phase_next  = '0;
                high_phase_next = '0;
                count_next      = '0;
                in_pause_next   = 1'b0;
                busy_next       = 1'b1;
            end
        end

        if (tick_fire)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = '0;
            out_tone_next   = 1'b0;
            out_last_next   = 1'b0;
            if (busy_reg && !in_pause_reg)
            begin
                out_sample_next = tone_sample;
                out_tone_next   = 1'b1;
                low_phase_next  = low_phase_reg + low_step_reg;
                high_phase_next = high_phase_reg + high_step_reg;
                if (tone_end)
                begin
                    count_next = '0;
                    if (cfg.pause_samples == '0)
                    begin
                        out_last_next = 1'b1;
                        busy_next     = 1'b0;
                    end
                    else
                    begin
                        in_pause_next = 1'b1;
                    end
                end
                else
                begin
                    count_next = count_inc[COUNT_BITS-1:0];
                end
            end
            else if (busy_reg)
            begin
                if (pause_end)
                begin
                    out_last_next = 1'b1;
                    busy_next     = 1'b0;
                    in_pause_next = 1'b0;
                    count_next    = '0;
                end
                else
                begin
                    count_next = count_inc[COUNT_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            in_pause_reg   <= 1'b0;
            count_reg      <= '0;
            low_phase_reg  <= '0;
            high_phase_reg <= '0;
            low_step_reg   <= '0;
            high_step_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            busy_reg       <= busy_next;
            in_pause_reg   <= in_pause_next;
            count_reg      <= count_next;
            low_phase_reg  <= low_phase_next;
            high_phase_reg <= high_phase_next;
            low_step_reg   <= low_step_next;
            high_step_reg  <= high_step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_cmd_reg <= in_cmd;
            in_key_reg <= in_key;
        end
        out_sample_reg <= out_sample_next;
        out_tone_reg   <= out_tone_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = out_sample_reg;
    assign out_tone_on = out_tone_reg;
    assign out_last    = out_last_reg;

endmodule

### rtl/core/dtmf_tone_generator_top.sv
// Top level of the DTMF dual-tone generator.
//
//  group   | dir | transaction carries
//  --------+-----+---------------------------------------------------------
//  s_axis  | in  | tdata = key_code[7:0]; tuser = cmd (0 tick, 1 key)
//  m_axis  | out | tdata = sample[15:0]; tuser = tone_on; tlast = last
//  cfg     | in  | cfg_we, cfg_addr (register index), cfg_wdata (22 bits)
//
// One transaction per cycle on the input while no tick waits on a full result
// register; a tick result passes the input register, then the result register,
// before it is presented.
// Key transactions update the tone state and produce no output transaction.
// A tick waiting in the input register holds while the result register is full
// and not being taken; s_tready drops only then.
// Reset clears the valid flags and tone state and loads register defaults.
module dtmf_tone_generator_top
    import dtg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,   // [7:0] key_code
    input  logic [0:0]            s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample
    output logic [0:0]            m_tuser,   // [0] tone_on
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg;

    dtg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dtg_core #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser[0]),
        .in_key      (s_tdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sample  (m_tdata),
        .out_tone_on (m_tuser[0]),
        .out_last    (m_tlast)
    );

    // silent samples (idle or pause) carry zero
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("silent sample is not zero");

    // input back-pressure only while the result register is blocked
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with free result register");

    // a stalled result is replaced only after it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule
